>>> src/cbpe_pkg.sv
// Shared types and constants for the clamped B-spline point evaluator.
package cbpe_pkg;

   typedef struct packed {
      logic               operation;
      logic [5:0]         point_index;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [16:0]        param_t;
   } cbpe_req_type;

   typedef struct packed {
      logic signed [31:0] result_x;
      logic signed [31:0] result_y;
   } cbpe_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_ULATCH,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_SUM_RD,
      ST_SUM_X,
      ST_SUM_Y,
      ST_SUM_ACC,
      ST_FIN,
      ST_PT_WAIT,
      ST_RESP
   } cbpe_state_type;

   localparam logic        OP_WRITE     = 1'b0;
   localparam logic        OP_EVAL      = 1'b1;
   localparam int          FRAC_BITS    = 16;
   localparam int          BASIS_SHIFT  = 30;
   localparam int          DEG_CAP      = 3;
   localparam int          MUL_W        = 33;
   localparam int          PROD_W       = 2 * MUL_W;
   localparam logic [31:0] BASIS_ONE    = 32'h4000_0000;
   localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
   localparam logic [1:0]  DIV_ONE      = 2'd1;
   localparam logic [1:0]  DIV_TWO      = 2'd2;
   localparam logic [1:0]  DIV_THREE    = 2'd3;
   localparam logic [1:0]  DIV_NONE     = 2'd0;

endpackage

>>> src/cbpe_mul.sv
// Shared signed multiplier with a registered product.
module cbpe_mul
   import cbpe_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] product
);

   logic signed [PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

   assign product = product_ff;

endmodule

>>> src/cbpe_point_mem.sv
// Control point storage: one write port, one registered read port.
module cbpe_point_mem #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [63:0]              wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [63:0]              rd_data
);

   logic [63:0] mem [0:DEPTH-1];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/clamped_bspline_point_eval_unit.sv
// Clamped B-spline point evaluator top level: sequencer, basis registers, sums.
//
//   channel | ports                         | role
//   --------+-------------------------------+--------------------------------
//   req     | req_valid/req_ready/req_data  | point write or evaluate request
//   rsp     | rsp_valid/rsp_ready/rsp_data  | evaluated curve point
//   csr     | csr_wr_en/csr_wr_data         | point_count register
//
// A write transaction is stored in the point memory when it is accepted. A
// special-case evaluation (one point, t at zero or at one) passes ST_PREP and
// ST_PT_WAIT before rsp_valid, with no points ST_PREP alone. A general
// evaluation runs the recursion terms (2*(p+1) per level p, levels 1..deg), then
// the weighted sums over deg+1 points, on the one shared multiplier. Reset clears
// the sequencer and point_count; the point memory is not cleared. req_ready is
// low from acceptance of an evaluation until its result is taken.
module clamped_bspline_point_eval_unit
   import cbpe_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int MAX_DEGREE = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_wr_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  cbpe_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output cbpe_rsp_type rsp_data
);

   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int IW = NW + 1;
   localparam int UW = FRAC_BITS + NW;
   localparam int DW = UW + 1;

   cbpe_state_type state_ff, state_in;

   logic [6:0]        count_ff, count_in;
   logic [16:0]       t_ff, t_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [1:0]        deg_ff, deg_in;
   logic [NW-1:0]     spans_ff, spans_in;
   logic [UW-1:0]     u_ff, u_in;
   logic [1:0]        p_ff, p_in;
   logic [1:0]        k_ff, k_in;
   logic              side_ff, side_in;
   logic [31:0]       acc_ff, acc_in;
   logic [31:0]       bas_ff [0:DEG_CAP];
   logic [31:0]       bas_in [0:DEG_CAP];
   logic signed [PROD_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   cbpe_rsp_type      rsp_ff, rsp_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [63:0]       mem_rdata;

   logic              req_fire;
   logic [NW-1:0]     n_sat;
   logic [1:0]        deg_c;
   logic [NW-1:0]     spans_c;
   logic [NW-1:0]     s_c;
   logic [IW-1:0]     j_c, pw;
   logic [NW-1:0]     kn_j, kn_jp, kn_j1, kn_jp1;
   logic [1:0]        dsel;
   logic signed [DW-1:0] delta_l, delta_r, delta_c;
   logic [31:0]       b_c, b_eff, q_c, term_c, sum_c;
   logic              special_c, last_term;

   function automatic logic [NW-1:0] knot_at(input logic [IW-1:0] idx,
                                             input logic [1:0]    dg,
                                             input logic [NW-1:0] cnt,
                                             input logic [NW-1:0] sp);
      logic [IW-1:0] dgw;
      dgw = IW'(dg);
      if (idx <= dgw) begin
         return '0;
      end else if (idx >= IW'(cnt)) begin
         return sp;
      end else begin
         return NW'(idx - dgw);
      end
   endfunction

   function automatic logic [31:0] scale_out(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] adj;
      adj = (v < 0) ? v + PROD_W'((1 << BASIS_SHIFT) - 1) : v;
      return adj[BASIS_SHIFT+31:BASIS_SHIFT];
   endfunction

   cbpe_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   cbpe_point_mem #(.DEPTH(MAX_POINTS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data ({req_data.point_y, req_data.point_x}),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

   assign mem_we    = req_fire && (req_data.operation == OP_WRITE)
                      && (int'(req_data.point_index) < MAX_POINTS);
   assign mem_waddr = AW'(req_data.point_index);

   assign n_sat   = (int'(count_ff) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(count_ff);
   assign deg_c   = (int'(n_ff) - 1 < MAX_DEGREE) ? 2'(n_ff - 1'b1) : 2'(MAX_DEGREE);
   assign spans_c = n_ff - NW'(deg_c);
   assign special_c = (n_ff == NW'(1)) || (t_ff == '0) || t_ff[16];

   assign s_c    = u_ff[UW-1:FRAC_BITS];
   assign j_c    = IW'(s_c) + IW'(k_ff);
   assign pw     = IW'(p_ff);
   assign kn_j   = knot_at(j_c, deg_ff, n_ff, spans_ff);
   assign kn_jp  = knot_at(j_c + pw, deg_ff, n_ff, spans_ff);
   assign kn_j1  = knot_at(j_c + IW'(1), deg_ff, n_ff, spans_ff);
   assign kn_jp1 = knot_at(j_c + pw + IW'(1), deg_ff, n_ff, spans_ff);
   assign dsel   = side_ff ? 2'(kn_jp1 - kn_j1) : 2'(kn_jp - kn_j);
   assign delta_l = $signed({1'b0, u_ff}) - $signed({1'b0, kn_j, 16'b0});
   assign delta_r = $signed({1'b0, kn_jp1, 16'b0}) - $signed({1'b0, u_ff});
   assign delta_c = side_ff ? delta_r : delta_l;
   assign b_c    = side_ff ? ((k_ff == deg_ff) ? '0 : bas_ff[k_ff + 2'd1]) : bas_ff[k_ff];
   assign b_eff  = (dsel == DIV_NONE) ? '0 : b_c;
   assign q_c    = (dsel == DIV_TWO) ? mul_p[48:17] : mul_p[47:16];
   assign term_c = (state_ff == ST_MUL_C) ? mul_p[64:33] : q_c;
   assign sum_c  = acc_ff + term_c;
   assign last_term = side_ff && (k_ff == deg_ff) && (p_ff == deg_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.operation == OP_EVAL)) state_in = ST_PREP;
         end
         ST_PREP: begin
            if (n_ff == '0) state_in = ST_RESP;
            else if (special_c) state_in = ST_PT_WAIT;
            else state_in = ST_ULATCH;
         end
         ST_ULATCH: state_in = ST_MUL_A;
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: begin
            if (dsel == DIV_THREE) state_in = ST_MUL_C;
            else if (last_term) state_in = ST_SUM_RD;
            else state_in = ST_MUL_A;
         end
         ST_MUL_C: state_in = last_term ? ST_SUM_RD : ST_MUL_A;
         ST_SUM_RD: state_in = ST_SUM_X;
         ST_SUM_X: state_in = ST_SUM_Y;
         ST_SUM_Y: state_in = ST_SUM_ACC;
         ST_SUM_ACC: state_in = (k_ff == deg_ff) ? ST_FIN : ST_SUM_RD;
         ST_FIN: state_in = ST_RESP;
         ST_PT_WAIT: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = csr_wr_en ? csr_wr_data : count_ff;
      t_in     = t_ff;
      n_in     = n_ff;
      deg_in   = deg_ff;
      spans_in = spans_ff;
      u_in     = u_ff;
      p_in     = p_ff;
      k_in     = k_ff;
      side_in  = side_ff;
      acc_in   = acc_ff;
      bas_in   = bas_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      rsp_in   = rsp_ff;
      mul_a    = '0;
      mul_b    = '0;
      mem_raddr = AW'(j_c);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               t_in = req_data.param_t;
               n_in = n_sat;
            end
         end
         ST_PREP: begin
            deg_in   = deg_c;
            spans_in = spans_c;
            mul_a    = MUL_W'({1'b0, t_ff[15:0]});
            mul_b    = MUL_W'({1'b0, spans_c});
            mem_raddr = ((n_ff == NW'(1)) || (t_ff == '0)) ? '0 : AW'(n_ff - 1'b1);
            rsp_in   = '0;
         end
         ST_ULATCH: begin
            u_in    = mul_p[UW-1:0];
            p_in    = 2'd1;
            k_in    = deg_ff - 2'd1;
            side_in = 1'b0;
            acc_in  = '0;
            sx_in   = '0;
            sy_in   = '0;
            for (int i = 0; i <= DEG_CAP; i++) begin
               bas_in[i] = (2'(i) == deg_ff) ? BASIS_ONE : '0;
            end
         end
         ST_MUL_A: begin
            mul_a = MUL_W'(delta_c);
            mul_b = MUL_W'({1'b0, b_eff});
         end
         ST_MUL_B, ST_MUL_C: begin
            if ((state_ff == ST_MUL_B) && (dsel == DIV_THREE)) begin
               mul_a = MUL_W'({1'b0, q_c});
               mul_b = MUL_W'({1'b0, RECIP3});
            end else if (!side_ff) begin
               acc_in  = sum_c;
               side_in = 1'b1;
            end else begin
               bas_in[k_ff] = sum_c;
               acc_in  = '0;
               side_in = 1'b0;
               if (k_ff == deg_ff) begin
                  if (p_ff == deg_ff) begin
                     k_in = '0;
                  end else begin
                     p_in = p_ff + 2'd1;
                     k_in = deg_ff - p_ff - 2'd1;
                  end
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         ST_SUM_X: begin
            mul_a = MUL_W'($signed(mem_rdata[31:0]));
            mul_b = MUL_W'({1'b0, bas_ff[k_ff]});
         end
         ST_SUM_Y: begin
            sx_in = sx_ff + mul_p;
            mul_a = MUL_W'($signed(mem_rdata[63:32]));
            mul_b = MUL_W'({1'b0, bas_ff[k_ff]});
         end
         ST_SUM_ACC: begin
            sy_in = sy_ff + mul_p;
            k_in  = k_ff + 2'd1;
         end
         ST_FIN: begin
            rsp_in.result_x = scale_out(sx_ff);
            rsp_in.result_y = scale_out(sy_ff);
         end
         ST_PT_WAIT: begin
            rsp_in.result_x = mem_rdata[31:0];
            rsp_in.result_y = mem_rdata[63:32];
         end
         ST_SUM_RD, ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      n_ff     <= n_in;
      deg_ff   <= deg_in;
      spans_ff <= spans_in;
      u_ff     <= u_in;
      p_ff     <= p_in;
      k_ff     <= k_in;
      side_ff  <= side_in;
      acc_ff   <= acc_in;
      bas_ff   <= bas_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      rsp_ff   <= rsp_in;
   end

   a_ready_excludes_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("req_ready and rsp_valid high together");

   a_term_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_B) |-> (mul_p[PROD_W-1:48] == '0))
      else $error("recursion product out of range");

   a_point_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM_RD) |-> (j_c < IW'(n_ff)))
      else $error("weighted sum reads beyond point count");

endmodule
